// File: design/pcc_pkg.sv
// Shared types, constants and arithmetic helpers of the clamped PID controller.
package pcc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FRAC       = 8;
  localparam int DFRAC      = 16;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ERR_W      = SAMPLE_W + 1;
  localparam int ACC_W      = 32;
  localparam int DIFF_W     = ACC_W + 1;
  localparam int T_W        = ACC_W + 3;
  localparam int MA_W       = GAIN_W + 2;
  localparam int MB_W       = T_W + 1;
  localparam int PROD_W     = MA_W + MB_W;
  localparam int DIV_STEPS  = ACC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_LIMIT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT    = 3'd7;

  typedef struct packed {
    logic                       operation;
    logic signed [SAMPLE_W-1:0] setpoint;
    logic signed [SAMPLE_W-1:0] position;
    logic signed [15:0]         preset_integral;
  } in_t;

  typedef struct packed {
    logic signed [15:0] control_out;
    logic               integral_limited;
  } out_t;

  typedef enum logic [1:0] {
    MUL_P,
    MUL_I,
    MUL_T,
    MUL_D
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     p_store;
    logic     isum_acc;
    logic     i_store;
    logic     div_start;
    logic     div_step;
    logic     div_write;
    logic     diff_store;
    logic     t_store;
    logic     dfs_update;
    logic     d_store;
    logic     preset_dfs;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic ig_zero;
    logic dg_zero;
    logic i_over;
    logic div_last;
    logic out_busy;
  } sts_t;

  function automatic logic signed [ACC_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'({1'b0, {(ACC_W-1){1'b1}}});
    lo = -hi - PROD_W'(1);
    if (x > hi) return hi[ACC_W-1:0];
    if (x < lo) return lo[ACC_W-1:0];
    return x[ACC_W-1:0];
  endfunction

  function automatic logic signed [15:0] clamp_sym(input logic signed [PROD_W-1:0] x,
                                                   input logic [LIM_W-1:0] lim);
    logic signed [PROD_W-1:0] l;
    l = $signed({{(PROD_W-LIM_W){1'b0}}, lim});
    if (x > l) return l[15:0];
    if (x < -l) return 16'(-l);
    return x[15:0];
  endfunction

endpackage

// File: design/pid_controller_clamped_terms.sv
// Top level of the clamped PID controller with integral back-calculation.
// Usage:
//   in_valid/in_stall/in_data carries one transaction: a control update
//   (operation 0) or a preset of the integral and derivative state (operation 1).
//   out_valid/out_stall/out_data returns exactly one result per transaction.
//   cfg_we/cfg_index/cfg_data writes the eight gain, coefficient and limit
//   registers; write them only while no transaction is in flight.
// Sequencing, one transaction at a time through a shared 18x36 multiplier:
//   an update steps the proportional, integral and derivative products in turn;
//   zero derivative gain skips the derivative steps and zero integral gain the
//   integral steps; with integral clamp the 32-step serial divider recomputes
//   the integral sum; a preset uses the divider only with nonzero integral gain.
//   A new transaction is accepted only after the previous result is emitted.
// Reset (rst_n low, synchronous) clears registers, integral sum and filter
// state; no transaction is pending afterward.
// A stalled result is held in the output register; the next transaction is
// accepted and computed, then waits for that register before it finishes.
module pid_controller_clamped_terms (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pcc_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pcc_pkg::out_t                 out_data
);
  import pcc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: design/pcc_ctrl.sv
// Sequencer of the PID controller: steps the shared multiplier and divider.
module pcc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pcc_pkg::sts_t sts,
  output pcc_pkg::cmd_t cmd
);
  import pcc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_P, S_PST, S_I, S_IST, S_DIV, S_DIVW,
    S_X, S_T, S_TST, S_D, S_DST, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.mul_sel = MUL_P;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_P;
        end
      end
      S_P: begin
        if (sts.op) begin
          cmd.preset_dfs = 1'b1;
          cmd.div_start  = !sts.ig_zero;
          state_nxt      = sts.ig_zero ? S_OUT : S_DIV;
        end else begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MUL_P;
          state_nxt   = S_PST;
        end
      end
      S_PST: begin
        cmd.p_store  = 1'b1;
        cmd.isum_acc = !sts.ig_zero;
        state_nxt    = sts.ig_zero ? S_X : S_I;
      end
      S_I: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_I;
        state_nxt   = S_IST;
      end
      S_IST: begin
        cmd.i_store   = 1'b1;
        cmd.div_start = sts.i_over;
        state_nxt     = sts.i_over ? S_DIV : S_X;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DIVW;
      end
      S_DIVW: begin
        cmd.div_write = 1'b1;
        state_nxt     = sts.op ? S_OUT : S_X;
      end
      S_X: begin
        cmd.diff_store = !sts.dg_zero;
        state_nxt      = sts.dg_zero ? S_OUT : S_T;
      end
      S_T: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_T;
        state_nxt   = S_TST;
      end
      S_TST: begin
        cmd.t_store = 1'b1;
        state_nxt   = S_D;
      end
      S_D: begin
        cmd.mul_go     = 1'b1;
        cmd.mul_sel    = MUL_D;
        cmd.dfs_update = 1'b1;
        state_nxt      = S_DST;
      end
      S_DST: begin
        cmd.d_store = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy) else $error("emit while output busy");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_P) else $error("load did not start sequence");
  a_div_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIVW |-> $past(state_r) == S_DIV) else $error("divider write out of order");

endmodule

// File: design/pcc_datapath.sv
// Datapath of the PID controller: registers, shared multiplier, serial divider.
module pcc_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  pcc_pkg::in_t                       in_data,
  input  logic                               out_stall,
  output logic                               out_valid,
  output pcc_pkg::out_t                      out_data,
  input  pcc_pkg::cmd_t                      cmd,
  output pcc_pkg::sts_t                      sts
);
  import pcc_pkg::*;

  logic [GAIN_W-1:0] prop_gain_r, integ_gain_r, deriv_gain_r, filter_coeff_r;
  logic [LIM_W-1:0]  prop_limit_r, integ_limit_r, deriv_limit_r, out_limit_r;

  logic                       op_r;
  logic signed [SAMPLE_W-1:0] pos_r;
  logic signed [15:0]         pre_r;
  logic signed [ERR_W-1:0]    err_r;
  logic signed [ACC_W-1:0]    isum_r, dfs_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [15:0]         pterm_r, iterm_r, dterm_r;
  logic                       ilim_r;
  logic signed [DIFF_W-1:0]   diff_r;
  logic signed [T_W-1:0]      t_r;
  logic [ACC_W-1:0]           div_q_r;
  logic [GAIN_W-1:0]          div_rem_r;
  logic                       div_neg_r;
  logic [DIV_CNT_W-1:0]       div_cnt_r;
  logic                       out_valid_r;
  out_t                       out_data_r;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic [GAIN_W:0]          fc_eff;
  logic signed [PROD_W-1:0] p_raw, i_raw, t_full, d_raw, ilim_w, x_full, sum_w;
  logic signed [15:0]       i_clamp, div_src;
  logic signed [ACC_W:0]    num_s, num_mag;
  logic signed [ACC_W-1:0]  x_sat;
  logic [GAIN_W:0]          div_shift;
  logic                     div_ge;
  logic [LIM_W-1:0]         olim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= '0;
      integ_gain_r   <= '0;
      deriv_gain_r   <= '0;
      filter_coeff_r <= '0;
      prop_limit_r   <= '0;
      integ_limit_r  <= '0;
      deriv_limit_r  <= '0;
      out_limit_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:    prop_gain_r    <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:   integ_gain_r   <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:   deriv_gain_r   <= cfg_data[GAIN_W-1:0];
        REG_FILTER_COEFF: filter_coeff_r <= cfg_data[GAIN_W-1:0];
        REG_PROP_LIMIT:   prop_limit_r   <= cfg_data[LIM_W-1:0];
        REG_INTEG_LIMIT:  integ_limit_r  <= cfg_data[LIM_W-1:0];
        REG_DERIV_LIMIT:  deriv_limit_r  <= cfg_data[LIM_W-1:0];
        REG_OUT_LIMIT:    out_limit_r    <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign fc_eff = (filter_coeff_r == '0) ? {1'b1, {GAIN_W{1'b0}}} : {1'b0, filter_coeff_r};

  always_comb begin
    case (cmd.mul_sel)
      MUL_P: begin
        mul_a = $signed({2'b00, prop_gain_r});
        mul_b = MB_W'(err_r);
      end
      MUL_I: begin
        mul_a = $signed({2'b00, integ_gain_r});
        mul_b = MB_W'(isum_r);
      end
      MUL_T: begin
        mul_a = $signed({1'b0, fc_eff});
        mul_b = MB_W'(diff_r);
      end
      MUL_D: begin
        mul_a = $signed({2'b00, deriv_gain_r});
        mul_b = MB_W'(t_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign p_raw  = (prod_r + (PROD_W'(1) <<< (FRAC - 1))) >>> FRAC;
  assign i_raw  = (prod_r + (PROD_W'(1) <<< (2*FRAC - 1))) >>> (2*FRAC);
  assign t_full = (prod_r + (PROD_W'(1) <<< (DFRAC - 1))) >>> DFRAC;
  assign d_raw  = (prod_r + (PROD_W'(1) <<< (FRAC + DFRAC - 1))) >>> (FRAC + DFRAC);
  assign ilim_w = $signed({{(PROD_W-LIM_W){1'b0}}, integ_limit_r});
  assign i_clamp = clamp_sym(i_raw, integ_limit_r);
  assign x_full = (-PROD_W'(pos_r)) <<< DFRAC;
  assign x_sat  = sat32(x_full);

  assign div_src = op_r ? pre_r : i_clamp;
  assign num_s   = $signed({div_src, {DFRAC{1'b0}}});
  assign num_mag = num_s[ACC_W] ? -num_s : num_s;
  assign div_shift = {div_rem_r, div_q_r[ACC_W-1]};
  assign div_ge    = div_shift >= {1'b0, integ_gain_r};

  assign olim  = (out_limit_r == '0) ? prop_limit_r : out_limit_r;
  assign sum_w = PROD_W'(pterm_r) + PROD_W'(iterm_r) + PROD_W'(dterm_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isum_r      <= '0;
      dfs_r       <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.isum_acc) isum_r <= sat32(PROD_W'(isum_r) + (PROD_W'(err_r) <<< FRAC));
      if (cmd.div_write) isum_r <= div_neg_r ? -$signed(div_q_r) : $signed(div_q_r);
      if (cmd.preset_dfs) dfs_r <= x_sat;
      if (cmd.dfs_update) dfs_r <= sat32(PROD_W'(dfs_r) + PROD_W'(t_r));
      if (cmd.div_start) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_data.operation;
      pos_r   <= in_data.position;
      pre_r   <= in_data.preset_integral;
      err_r   <= ERR_W'(in_data.setpoint) - ERR_W'(in_data.position);
      pterm_r <= '0;
      iterm_r <= '0;
      dterm_r <= '0;
      ilim_r  <= 1'b0;
    end
    if (cmd.mul_go) prod_r <= mul_a * mul_b;
    if (cmd.p_store) pterm_r <= clamp_sym(p_raw, prop_limit_r);
    if (cmd.i_store) begin
      iterm_r <= i_clamp;
      ilim_r  <= sts.i_over;
    end
    if (cmd.diff_store) diff_r <= DIFF_W'(x_sat) - DIFF_W'(dfs_r);
    if (cmd.t_store) t_r <= t_full[T_W-1:0];
    if (cmd.d_store) dterm_r <= clamp_sym(d_raw, deriv_limit_r);
    if (cmd.div_start) begin
      div_q_r   <= num_mag[ACC_W-1:0];
      div_rem_r <= '0;
      div_neg_r <= num_s[ACC_W];
    end else if (cmd.div_step) begin
      div_rem_r <= div_ge ? 16'(div_shift - {1'b0, integ_gain_r}) : div_shift[GAIN_W-1:0];
      div_q_r   <= {div_q_r[ACC_W-2:0], div_ge};
    end
    if (cmd.emit) begin
      out_data_r.control_out      <= op_r ? 16'sd0 : clamp_sym(sum_w, olim);
      out_data_r.integral_limited <= op_r ? 1'b0 : ilim_r;
    end
  end

  assign sts.op       = op_r;
  assign sts.ig_zero  = (integ_gain_r == '0);
  assign sts.dg_zero  = (deriv_gain_r == '0);
  assign sts.i_over   = (i_raw > ilim_w) || (i_raw < -ilim_w);
  assign sts.div_last = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.out_busy = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_write |-> div_cnt_r == DIV_CNT_W'(DIV_STEPS)) else $error("divider step count");
  a_preset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && op_r |=> out_data_r.control_out == 16'sd0 && !out_data_r.integral_limited)
    else $error("preset result not zero");
  a_iterm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.i_store |=> (iterm_r <= $signed({1'b0, integ_limit_r}))
                 && (iterm_r >= -$signed({1'b0, integ_limit_r})))
    else $error("integral term beyond limit");

endmodule

// File: dv/pid_controller_clamped_terms_test.sv
// Self-checking testbench of the clamped PID controller: directed table, random updates and presets.
`timescale 1ns / 1ps
module pid_controller_clamped_terms_test;
  import pcc_pkg::*;

  localparam int NUM_RAND  = 1800;
  localparam int WDOG_MAX  = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  pid_controller_clamped_terms dut (.*);

  always #1 clk = ~clk;

  longint gain_p, gain_i, gain_d, coeff, lim_p, lim_i, lim_d, lim_o;
  longint isum, dstate;
  out_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  typedef struct {
    logic op;
    int   sp;
    int   pos;
    int   pre;
    bit   known;
    int   ctl;
    logic lim;
  } row_t;

  function automatic longint sat_32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint rnd_shift(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint x, longint l);
    if (x > l) return l;
    if (x < -l) return -l;
    return x;
  endfunction

  function automatic out_t predict_drive(logic op, longint sp, longint pos, longint pre);
    out_t r;
    longint err, pt, it, dt, fc, ol, x, t;
    r = '0;
    it = 0;
    dt = 0;
    if (op) begin
      if (gain_i != 0) isum = sat_32((pre * 65536) / gain_i);
      dstate = sat_32(-pos * 65536);
      return r;
    end
    fc = (coeff != 0) ? coeff : 65536;
    ol = (lim_o != 0) ? lim_o : lim_p;
    err = sp - pos;
    pt = clip(rnd_shift(gain_p * err, FRAC), lim_p);
    if (gain_i != 0) begin
      isum = sat_32(isum + err * 256);
      it = rnd_shift(gain_i * isum, 2 * FRAC);
      if (it > lim_i || it < -lim_i) begin
        it = clip(it, lim_i);
        r.integral_limited = 1'b1;
        isum = sat_32((it * 65536) / gain_i);
      end
    end
    if (gain_d != 0) begin
      x = sat_32(-pos * 65536);
      t = rnd_shift(fc * (x - dstate), DFRAC);
      dt = clip(rnd_shift(gain_d * t, FRAC + DFRAC), lim_d);
      dstate = sat_32(dstate + t);
    end
    r.control_out = 16'(clip(pt + it + dt, ol));
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PROP_GAIN:    gain_p = val & 16'hffff;
      REG_INTEG_GAIN:   gain_i = val & 16'hffff;
      REG_DERIV_GAIN:   gain_d = val & 16'hffff;
      REG_FILTER_COEFF: coeff  = val & 16'hffff;
      REG_PROP_LIMIT:   lim_p  = val & 15'h7fff;
      REG_INTEG_LIMIT:  lim_i  = val & 15'h7fff;
      REG_DERIV_LIMIT:  lim_d  = val & 15'h7fff;
      default:          lim_o  = val & 15'h7fff;
    endcase
  endtask

  task automatic set_gains(int p, int i, int d, int f, int lp, int li, int ld, int lo);
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_INTEG_GAIN, i);
    write_reg(REG_DERIV_GAIN, d);
    write_reg(REG_FILTER_COEFF, f);
    write_reg(REG_PROP_LIMIT, lp);
    write_reg(REG_INTEG_LIMIT, li);
    write_reg(REG_DERIV_LIMIT, ld);
    write_reg(REG_OUT_LIMIT, lo);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send(logic op, int sp, int pos, int pre, bit known, int ctl, logic lim);
    out_t r;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{operation: op, setpoint: 16'(sp), position: 16'(pos),
                 preset_integral: 16'(pre)};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_drive(op, longint'(signed'(16'(sp))), longint'(signed'(16'(pos))),
                      longint'(signed'(16'(pre))));
    if (known && (r.control_out !== 16'(ctl) || r.integral_limited !== lim))
      $display("%0t table row disagrees with predictor: %h", $time, r);
    if (known) r = '{control_out: 16'(ctl), integral_limited: lim};
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (quiet) out_stall <= 1'b0;
      else if ($urandom_range(0, 7) == 0) out_stall <= ~out_stall;
    end
  end

  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected transaction: actual %h", $time, out_data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.control_out !== e.control_out ||
            out_data.integral_limited !== e.integral_limited) begin
          $display("%0t mismatch: expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("pid_controller_clamped_terms_test NOT OK");
      $finish;
    end
  end

  row_t table_rows[] = '{
    '{1'b0, 100, 0, 0, 1'b1, 32767, 1'b0},
    '{1'b0, 32767, -32768, 0, 1'b0, 0, 1'b0},
    '{1'b0, -32768, 32767, 0, 1'b0, 0, 1'b0},
    '{1'b1, 0, 1000, 5000, 1'b1, 0, 1'b0},
    '{1'b0, 0, 0, 0, 1'b0, 0, 1'b0},
    '{1'b1, 0, -32768, -32768, 1'b1, 0, 1'b0},
    '{1'b0, 32767, 32767, 0, 1'b0, 0, 1'b0},
    '{1'b1, 0, 32767, 32767, 1'b1, 0, 1'b0},
    '{1'b0, -32768, -32768, -1, 1'b0, 0, 1'b0},
    '{1'b0, 32767, -32768, 0, 1'b0, 0, 1'b0},
    '{1'b0, 32767, -32768, 0, 1'b0, 0, 1'b0}
  };

  initial begin
    int s, phase;
    gain_p = 0; gain_i = 0; gain_d = 0; coeff = 0;
    lim_p = 0; lim_i = 0; lim_d = 0; lim_o = 0;
    isum = 0; dstate = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(1'b0, 100, 0, 0, 1'b1, 0, 1'b0);
    drain();
    set_gains(65535, 65535, 65535, 0, 32767, 32767, 32767, 0);
    foreach (table_rows[k])
      send(table_rows[k].op, table_rows[k].sp, table_rows[k].pos, table_rows[k].pre,
           table_rows[k].known, table_rows[k].ctl, table_rows[k].lim);
    drain();
    set_gains(256, 0, 256, 1, 0, 0, 0, 32767);
    send(1'b0, 1000, -500, 0, 1'b0, 0, 1'b0);
    send(1'b1, 0, 5, 77, 1'b0, 0, 1'b0);
    drain();
    for (phase = 0; phase < 6; phase++) begin
      drain();
      if (phase == 5) set_gains(0, 0, 0, 65535, 32767, 0, 32767, 1);
      else set_gains($urandom_range(0, 65535), ($urandom_range(0, 3) == 0) ? 0 :
                     $urandom_range(1, 2000), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 32767),
                     $urandom_range(0, 32767), $urandom_range(0, 32767),
                     ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 32767));
      quiet = (phase == 5);
      for (s = 0; s < NUM_RAND / 6; s++) begin
        if ($urandom_range(0, 3) == 0)
          send($urandom_range(0, 9) == 0, $urandom_range(0, 65535),
               $urandom_range(0, 65535), $urandom_range(0, 65535), 1'b0, 0, 1'b0);
        else
          send($urandom_range(0, 19) == 0, $urandom_range(0, 600) - 300,
               $urandom_range(0, 600) - 300, $urandom_range(0, 65535), 1'b0, 0, 1'b0);
      end
    end
    drain();
    if (errors == 0) $display("pid_controller_clamped_terms_test OK");
    else $display("pid_controller_clamped_terms_test NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
design/pcc_pkg.sv
design/pcc_ctrl.sv
design/pcc_datapath.sv
design/pid_controller_clamped_terms.sv
dv/pid_controller_clamped_terms_test.sv
